>>> src/clb_pkg.sv
// shared types and character codes for the console line edit buffer
package clb_pkg;

	// operation codes of an input request
	localparam logic [1:0] OP_CHAR  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	// echo modes
	localparam logic [1:0] ECHO_NONE  = 2'd0;
	localparam logic [1:0] ECHO_CHAR  = 2'd1;
	localparam logic [1:0] ECHO_ERASE = 2'd2;

	// host requests
	localparam logic [1:0] HOST_NONE  = 2'd0;
	localparam logic [1:0] HOST_PROCS = 2'd1;
	localparam logic [1:0] HOST_KILL  = 2'd2;

	// read status codes
	localparam logic [1:0] RS_BYTE  = 2'd0;
	localparam logic [1:0] RS_EMPTY = 2'd1;
	localparam logic [1:0] RS_EOF   = 2'd2;
	localparam logic [1:0] RS_NONE  = 2'd3;

	// character codes
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CTL_D  = 8'h04;
	localparam logic [7:0] CTL_U  = 8'h15;
	localparam logic [7:0] CTL_H  = 8'h08;
	localparam logic [7:0] CTL_P  = 8'h10;
	localparam logic [7:0] CTL_C  = 8'h03;

	localparam logic [8:0] ERASE_MAX = 9'h1FF;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture the input request
		logic exec;      // run the first step of the request
		logic kill_rd;   // read the character before the edit index
		logic kill_chk;  // erase it unless it is a newline
		logic rd_fin;    // finish a read from the fetched byte
		logic out_load;  // move the result into the output register
	} clb_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic kill;      // request is a kill-line
		logic rd_mem;    // read request with committed data
		logic kill_end;  // nothing uncommitted is left
		logic kill_nl;   // fetched character is a newline
		logic out_free;  // output register can take a result
	} clb_sts_t;

endpackage

>>> src/clb_ctrl.sv
// controller state machine for the console line edit buffer
module clb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  clb_pkg::clb_sts_t sts,
	output clb_pkg::clb_cmd_t cmd
);
	import clb_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_KADR = 6'b000100,
		S_KCHK = 6'b001000,
		S_RCHK = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.kill) begin
					state_d = S_KADR;
				end else if (sts.rd_mem) begin
					state_d = S_RCHK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_KADR: begin
				if (sts.kill_end) begin
					state_d = S_DONE;
				end else begin
					cmd.kill_rd = 1'b1;
					state_d = S_KCHK;
				end
			end
			S_KCHK: begin
				cmd.kill_chk = 1'b1;
				state_d = sts.kill_nl ? S_DONE : S_KADR;
			end
			S_RCHK: begin
				cmd.rd_fin = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> src/clb_dp.sv
// datapath of the console line edit buffer: indices, line ring and result registers
module clb_dp #(
	parameter int BUF_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  clb_pkg::clb_cmd_t cmd,
	output clb_pkg::clb_sts_t sts,
	input  logic [1:0]        opcode,
	input  logic [7:0]        in_char,
	input  logic              read_started,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        echo_mode,
	output logic [7:0]        echo_char,
	output logic [8:0]        erase_count,
	output logic              line_committed,
	output logic [1:0]        host_request,
	output logic [1:0]        read_status,
	output logic [7:0]        read_byte,
	output logic              line_end
);
	import clb_pkg::*;

	localparam int IW = $clog2(2 * BUF_DEPTH);
	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam logic [IW-1:0] IDX_LAST = IW'(2 * BUF_DEPTH - 1);
	localparam logic [IW:0]   IDX_MOD  = (IW + 1)'(2 * BUF_DEPTH);
	localparam logic [IW-1:0] DEPTH_I  = IW'(BUF_DEPTH);
	localparam logic [IW-1:0] DEPTH_M1 = IW'(BUF_DEPTH - 1);

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] v);
		return (v == IDX_LAST) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] v);
		return (v == '0) ? IDX_LAST : v - 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_diff(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] t;
		t = {1'b0, a} + IDX_MOD - {1'b0, b};
		return (a >= b) ? (a - b) : t[IW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot(input logic [IW-1:0] v);
		logic [IW-1:0] s;
		s = (v >= DEPTH_I) ? (v - DEPTH_I) : v;
		return s[AW-1:0];
	endfunction

	// captured request
	logic [1:0] op_q;
	logic [7:0] ch_q;
	logic       started_q;

	// ring indices
	logic [IW-1:0] read_idx_q, commit_idx_q, edit_idx_q;

	// pending result
	logic [1:0] res_echo_q;
	logic [7:0] res_char_q;
	logic [8:0] erase_n_q;
	logic       res_commit_q;
	logic [1:0] res_host_q;
	logic [1:0] res_rstat_q;
	logic [7:0] res_byte_q;
	logic       res_lend_q;

	// line ring
	logic [7:0]    mem_q [BUF_DEPTH];
	logic [7:0]    rdata_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata;

	logic [IW-1:0] occ;
	logic [IW-1:0] edit_inc;
	logic [IW-1:0] edit_dec;
	logic [7:0]    mapped;
	logic          has_room;
	logic          is_plain;

	assign occ      = idx_diff(edit_idx_q, read_idx_q);
	assign edit_inc = idx_inc(edit_idx_q);
	assign edit_dec = idx_dec(edit_idx_q);
	assign mapped   = (ch_q == CH_CR || ch_q == CH_FF) ? CH_NL : ch_q;
	assign has_room = (occ < DEPTH_I);

	always_comb begin
		case (ch_q) inside
			CTL_P, CTL_C, CTL_U, CTL_H, CH_DEL, CH_NUL: is_plain = 1'b0;
			default: is_plain = 1'b1;
		endcase
	end

	// status
	assign sts.kill     = (op_q == OP_CHAR) && (ch_q == CTL_U);
	assign sts.rd_mem   = (op_q == OP_READ) && (read_idx_q != commit_idx_q);
	assign sts.kill_end = (edit_idx_q == commit_idx_q);
	assign sts.kill_nl  = (rdata_q == CH_NL);
	assign sts.out_free = !out_valid || !out_stall;

	// ring ports
	assign mem_we    = cmd.exec && (op_q == OP_CHAR) && is_plain && has_room;
	assign mem_waddr = slot(edit_idx_q);
	assign mem_wdata = mapped;
	assign mem_re    = (cmd.exec && sts.rd_mem) || cmd.kill_rd;
	assign mem_raddr = cmd.kill_rd ? slot(edit_dec) : slot(read_idx_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	// captured request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= opcode;
			ch_q      <= in_char;
			started_q <= read_started;
		end
	end

	// indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_idx_q   <= '0;
			commit_idx_q <= '0;
			edit_idx_q   <= '0;
		end else begin
			if (cmd.exec) begin
				case (op_q)
					OP_CHAR: begin
						if ((ch_q == CTL_H || ch_q == CH_DEL) && !sts.kill_end) begin
							edit_idx_q <= edit_dec;
						end else if (is_plain && has_room) begin
							edit_idx_q <= edit_inc;
							if (mapped == CH_NL || mapped == CTL_D || occ == DEPTH_M1) begin
								commit_idx_q <= edit_inc;
							end
						end
					end
					OP_FLUSH: begin
						commit_idx_q <= edit_idx_q;
					end
					default: begin
					end
				endcase
			end
			if (cmd.kill_chk && !sts.kill_nl) begin
				edit_idx_q <= edit_dec;
			end
			if (cmd.rd_fin && (rdata_q != CTL_D || !started_q)) begin
				read_idx_q <= idx_inc(read_idx_q);
			end
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_echo_q   <= ECHO_NONE;
			res_char_q   <= '0;
			erase_n_q    <= '0;
			res_commit_q <= 1'b0;
			res_host_q   <= HOST_NONE;
			res_rstat_q  <= RS_NONE;
			res_byte_q   <= '0;
			res_lend_q   <= 1'b0;
			case (op_q)
				OP_CHAR: begin
					case (ch_q) inside
						CTL_P: res_host_q <= HOST_PROCS;
						CTL_C: res_host_q <= HOST_KILL;
						CTL_H, CH_DEL: begin
							if (!sts.kill_end) begin
								res_echo_q <= ECHO_ERASE;
								erase_n_q  <= 9'd1;
							end
						end
						default: begin
							if (is_plain && has_room) begin
								res_echo_q <= ECHO_CHAR;
								res_char_q <= mapped;
								res_commit_q <= (mapped == CH_NL) || (mapped == CTL_D) ||
									(occ == DEPTH_M1);
							end
						end
					endcase
				end
				OP_READ: begin
					if (!sts.rd_mem) begin
						res_rstat_q <= RS_EMPTY;
					end
				end
				OP_FLUSH: begin
					res_commit_q <= !sts.kill_end;
				end
				default: begin
				end
			endcase
		end
		if (cmd.kill_chk && !sts.kill_nl) begin
			res_echo_q <= ECHO_ERASE;
			erase_n_q  <= (erase_n_q == ERASE_MAX) ? erase_n_q : erase_n_q + 9'd1;
		end
		if (cmd.rd_fin) begin
			if (rdata_q == CTL_D) begin
				res_rstat_q <= RS_EOF;
			end else begin
				res_rstat_q <= RS_BYTE;
				res_byte_q  <= rdata_q;
				res_lend_q  <= (rdata_q == CH_NL);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			echo_mode      <= res_echo_q;
			echo_char      <= res_char_q;
			erase_count    <= (res_echo_q == ECHO_ERASE) ? erase_n_q : 9'd0;
			line_committed <= res_commit_q;
			host_request   <= res_host_q;
			read_status    <= res_rstat_q;
			read_byte      <= res_byte_q;
			line_end       <= res_lend_q;
		end
	end

endmodule

>>> src/console_line_edit_buffer_top.sv
// top level of the console line edit buffer
//
// input channel (in_valid / in_stall) takes one request: opcode, in_char,
// read_started. opcode selects a received character, a one byte read of
// committed text, a commit of the partial line, or no operation.
// output channel (out_valid / out_stall) returns exactly one result per
// request: echo action, commit flag, host request and read outcome.
// after accept, characters, flush, no-op and empty reads pass the execute
// and done states; a read that fetches a byte from the ring adds a read
// finish state; a kill-line walks back through the uncommitted text, each
// erased character costing one ring read and one compare.
// one request is in work at a time: in_stall is low only while the
// controller is idle, so the next request waits until the last result
// is in the output register. the controller's state walk sets the pace.
// the result sits in an output register; a stalled receiver holds it and
// the block finishes the next request, then waits in its done state.
// reset clears the three ring indices, the controller and out_valid;
// the ring contents are left as they are and are never read unwritten.
module console_line_edit_buffer_top #(
	parameter int BUF_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] in_char,
	input  logic       read_started,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] echo_mode,
	output logic [7:0] echo_char,
	output logic [8:0] erase_count,
	output logic       line_committed,
	output logic [1:0] host_request,
	output logic [1:0] read_status,
	output logic [7:0] read_byte,
	output logic       line_end
);
	import clb_pkg::*;

	// command and status between the sequencer and the datapath
	clb_cmd_t cmd;
	clb_sts_t sts;

	// sequencer: idle, execute, kill-line walk, read finish, done
	clb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// indices, ring storage and the output register
	clb_dp #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.in_char        (in_char),
		.read_started   (read_started),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.echo_mode      (echo_mode),
		.echo_char      (echo_char),
		.erase_count    (erase_count),
		.line_committed (line_committed),
		.host_request   (host_request),
		.read_status    (read_status),
		.read_byte      (read_byte),
		.line_end       (line_end)
	);

endmodule

>>> src/clb_chk.sv
// port checker for the console line edit buffer and its bind
module clb_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] echo_mode,
	input logic [7:0] echo_char,
	input logic [8:0] erase_count,
	input logic [1:0] read_status,
	input logic [7:0] read_byte,
	input logic       line_end
);
	import clb_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(echo_mode) &&
		$stable(echo_char) && $stable(erase_count) && $stable(read_status) &&
		$stable(read_byte))
		else $error("stalled result changed");

	// one request in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	// erase count only with an erase echo
	a_erase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && echo_mode != ECHO_ERASE |-> erase_count == 9'd0)
		else $error("erase count without erase echo");

	// read byte fields only with a delivered byte
	a_rbyte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_status != RS_BYTE |-> read_byte == 8'd0 && !line_end)
		else $error("read byte without delivery");

	// line end marks a newline
	a_lend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_end |-> read_byte == CH_NL)
		else $error("line end on a non-newline byte");

endmodule

bind console_line_edit_buffer_top clb_chk u_clb_chk (.*);
